// File: sv/pplru_pkg.sv
`timescale 1ns / 1ps
// Package for the physical page pool: request kinds, status codes and the
// request and result item structs. No dependencies.
package pplru_pkg;

  localparam int unsigned PageW  = 8;
  localparam int unsigned CountW = 9;

  typedef enum logic [2:0] {
    KIND_MAP    = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_FREE   = 3'd2,
    KIND_UNMAP  = 3'd3,
    KIND_TOUCH  = 3'd4,
    KIND_LOCK   = 3'd5,
    KIND_UNLOCK = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EVICT  = 2'd1,
    ST_NONE   = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] virtual_address;
    logic [3:0]  mip_level;
    logic [11:0] page_index;
    logic [31:0] frame;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PageW-1:0]  page;
    logic              hit;
    logic [CountW-1:0] free_count;
  } rsp_t;

endpackage

// File: sv/pplru_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pplru_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/physical_page_pool_lru_map_unit.sv
`timescale 1ns / 1ps
// Top level of the physical page pool with address map, free stack and LRU
// eviction. Depends on pplru_pkg and pplru_ram.
//
// Usage:
//   Requests enter on req_valid_i/req_ready_o as one req_t item; each request
//   yields exactly one rsp_t item on rsp_valid_o/rsp_ready_i.
//   One request is in work at a time. Free, unmap, touch, lock, unlock and
//   unused kinds go straight from accept to the result. An allocate with a
//   nonempty free stack passes through a free stack read, then an update.
//   A map request, and an allocate on an empty free stack, scan every page
//   record through the record memories, one record per cycle; a map miss
//   then pops the free stack as well when the stack is not empty.
//   The scan over the record memories sets the rate of map requests; a miss
//   that pops the free stack adds the pop to it.
//   Reset makes all pages free and unmapped with no clearing pass: the free
//   stack's initial contents come from a low-water mark, and flags are
//   flip-flops cleared at once.
//   A finished result sits in the output register; if the receiver stalls,
//   the next request may be accepted but its result waits until the output
//   register is free.
module physical_page_pool_lru_map_unit
  import pplru_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam logic [IW:0] NumP = (IW + 1)'(NUM_PAGES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_POP_RD, S_POP, S_RESP
  } state_e;

  state_e          state_q;
  req_t            req_q;
  logic [IW:0]     cnt_q;
  logic            rd_vld_q;
  logic [IW-1:0]   rd_idx_q;
  logic            hit_fnd_q, vic_fnd_q;
  logic [IW-1:0]   hit_idx_q, vic_idx_q;
  logic [31:0]     vic_stamp_q;
  logic [IW:0]     top_q, lo_q;
  logic [NUM_PAGES-1:0] mapped_q, locked_q, free_q;
  rsp_t            rsp_q, out_q;
  logic            out_valid_q;

  // memory ports
  logic            va_we, st_we, stk_we;
  logic [IW-1:0]   va_waddr, st_waddr, stk_waddr, rec_raddr;
  logic [35:0]     va_wdata, va_rdata;
  logic [31:0]     st_wdata, st_rdata;
  logic [IW-1:0]   stk_wdata, stk_rdata;

  logic [IW:0]     pop_slot;
  logic [IW-1:0]   pop_page;
  logic            in_acc, idx_ok, scan_end, free_push, out_load;
  logic [IW-1:0]   in_idx;

  assign in_acc   = req_valid_i && req_ready_o;
  assign in_idx   = req_i.page_index[IW-1:0];
  assign idx_ok   = {1'b0, req_i.page_index} < 13'(NUM_PAGES);
  assign pop_slot = top_q - 1'b1;
  // Slots below the low-water mark were never written: they hold their index.
  assign pop_page = (pop_slot < lo_q) ? pop_slot[IW-1:0] : stk_rdata;
  assign scan_end = (state_q == S_SCAN) && (cnt_q == NumP) && !rd_vld_q;
  assign rec_raddr = cnt_q[IW-1:0];
  // Push a freed page unless it is already on the stack.
  assign free_push = in_acc && idx_ok && (req_i.kind == KIND_FREE) &&
                     !free_q[in_idx] && (top_q < NumP);
  // Move the finished result into the output register once it is free.
  assign out_load = (state_q == S_RESP) && (!out_valid_q || rsp_ready_i);

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  always_comb begin
    va_we     = 1'b0;
    va_waddr  = '0;
    va_wdata  = {req_q.mip_level, req_q.virtual_address};
    st_we     = 1'b0;
    st_waddr  = '0;
    st_wdata  = req_q.frame;
    stk_we    = free_push;
    stk_waddr = top_q[IW-1:0];
    stk_wdata = in_idx;
    if (in_acc && idx_ok) begin
      if (req_i.kind == KIND_TOUCH) begin
        st_we    = 1'b1;
        st_waddr = in_idx;
        st_wdata = req_i.frame;
      end
    end
    if (scan_end && req_q.kind == KIND_MAP) begin
      if (hit_fnd_q) begin
        st_we    = 1'b1;
        st_waddr = hit_idx_q;
      end else if (top_q == '0 && vic_fnd_q) begin
        va_we    = 1'b1;
        va_waddr = vic_idx_q;
        st_we    = 1'b1;
        st_waddr = vic_idx_q;
      end
    end
    if (state_q == S_POP) begin
      st_we    = 1'b1;
      st_waddr = pop_page;
      if (req_q.kind == KIND_MAP) begin
        va_we    = 1'b1;
        va_waddr = pop_page;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      rsp_q       <= '0;
      out_q       <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      hit_fnd_q   <= 1'b0;
      vic_fnd_q   <= 1'b0;
      hit_idx_q   <= '0;
      vic_idx_q   <= '0;
      vic_stamp_q <= '0;
      top_q       <= NumP;
      lo_q        <= NumP;
      mapped_q    <= '0;
      locked_q    <= '0;
      free_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_q       <= rsp_q;
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q            <= req_i;
            rsp_q.page       <= '0;
            rsp_q.hit        <= 1'b0;
            cnt_q            <= '0;
            rd_vld_q         <= 1'b0;
            hit_fnd_q        <= 1'b0;
            vic_fnd_q        <= 1'b0;
            rsp_q.free_count <= free_push ? CountW'(top_q + 1'b1) : CountW'(top_q);
            case (req_i.kind) inside
              KIND_MAP: begin
                state_q      <= S_SCAN;
                rsp_q.status <= ST_OK;
              end
              KIND_ALLOC: begin
                state_q      <= (top_q != '0) ? S_POP_RD : S_SCAN;
                rsp_q.status <= ST_OK;
              end
              [KIND_FREE:KIND_UNLOCK]: begin
                state_q      <= S_RESP;
                rsp_q.status <= idx_ok ? ST_OK : ST_BADIDX;
                // a double free falls through and changes nothing
                if (free_push) begin
                  mapped_q[in_idx] <= 1'b0;
                  locked_q[in_idx] <= 1'b0;
                  free_q[in_idx]   <= 1'b1;
                  top_q            <= top_q + 1'b1;
                end else if (idx_ok && req_i.kind == KIND_UNMAP) begin
                  mapped_q[in_idx] <= 1'b0;
                end else if (idx_ok && req_i.kind == KIND_LOCK) begin
                  locked_q[in_idx] <= 1'b1;
                end else if (idx_ok && req_i.kind == KIND_UNLOCK) begin
                  locked_q[in_idx] <= 1'b0;
                end
              end
              default: begin
                state_q      <= S_RESP;
                rsp_q.status <= ST_OK;
              end
            endcase
          end
        end
        S_SCAN: begin
          // issue one record read per cycle, evaluate it in the next cycle
          rd_vld_q <= (cnt_q < NumP);
          rd_idx_q <= cnt_q[IW-1:0];
          if (cnt_q < NumP) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (rd_vld_q && mapped_q[rd_idx_q]) begin
            if (!hit_fnd_q && va_rdata[31:0] == req_q.virtual_address) begin
              hit_fnd_q <= 1'b1;
              hit_idx_q <= rd_idx_q;
            end
            if (!locked_q[rd_idx_q] && (!vic_fnd_q || st_rdata < vic_stamp_q)) begin
              vic_fnd_q   <= 1'b1;
              vic_idx_q   <= rd_idx_q;
              vic_stamp_q <= st_rdata;
            end
          end
          if (scan_end) begin
            if (req_q.kind == KIND_MAP && hit_fnd_q) begin
              state_q    <= S_RESP;
              rsp_q.page <= PageW'(hit_idx_q);
              rsp_q.hit  <= 1'b1;
            end else if (req_q.kind == KIND_MAP && top_q != '0) begin
              state_q <= S_POP_RD;
            end else if (vic_fnd_q) begin
              state_q      <= S_RESP;
              rsp_q.status <= ST_EVICT;
              rsp_q.page   <= PageW'(vic_idx_q);
              // a map keeps the victim mapped under its new address
              mapped_q[vic_idx_q] <= (req_q.kind == KIND_MAP);
            end else begin
              state_q      <= S_RESP;
              rsp_q.status <= ST_NONE;
            end
          end
        end
        S_POP_RD: state_q <= S_POP;
        S_POP: begin
          top_q            <= pop_slot;
          rsp_q.free_count <= CountW'(pop_slot);
          if (pop_slot < lo_q) begin
            lo_q <= pop_slot;
          end
          free_q[pop_page] <= 1'b0;
          if (req_q.kind == KIND_MAP) begin
            mapped_q[pop_page] <= 1'b1;
          end
          rsp_q.page <= PageW'(pop_page);
          state_q    <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  pplru_ram #(.Width(36), .Depth(NUM_PAGES)) u_va_ram (
    .clk_i   (clk_i),
    .we_i    (va_we),
    .waddr_i (va_waddr),
    .wdata_i (va_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (va_rdata)
  );

  pplru_ram #(.Width(32), .Depth(NUM_PAGES)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (st_rdata)
  );

  pplru_ram #(.Width(IW), .Depth(NUM_PAGES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (pop_slot[IW-1:0]),
    .rdata_o (stk_rdata)
  );

endmodule
